@@ design/msp_pkg.sv @@
// Shared types, codes and helpers for the multi-channel servo pulse generator.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  // Field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CH_W      = 5;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned PIN_W     = 18;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned HIGH_W    = 12;
  localparam int unsigned GAP_W     = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_ALL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd3;

  // Frame phases
  localparam logic [PHASE_W-1:0] PH_LEAD = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FALL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GAP  = 2'd2;

  // Reset values
  localparam logic [POS_W-1:0]  POS_RESET  = 8'd128;
  localparam logic [POS_W-1:0]  MIN_RESET  = 8'd0;
  localparam logic [POS_W-1:0]  MAX_RESET  = 8'd254;
  localparam logic [HIGH_W-1:0] HIGH_RESET = 12'd256;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd4096;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  channel;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_levels;
    logic               accepted;
    logic [POS_W-1:0]   read_value;
    logic [PHASE_W-1:0] phase_now;
  } out_item_t;

  // Frame events from the timer to the channel bank
  typedef struct packed {
    logic fall_tick;
    logic frame_start;
  } frame_ctl_t;

  // Max wins when exceeded, else min applies
  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] mn,
                                                 input logic [POS_W-1:0] mx);
    logic [POS_W-1:0] r;
    r = p;
    if (p > mx) begin
      r = mx;
    end else if (p < mn) begin
      r = mn;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/msp_stream_if.sv @@
// Valid/ready stream interface carrying one payload struct.
`timescale 1ns / 1ps
`default_nettype none

interface msp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/msp_frame_ctrl.sv @@
// Frame timer: phase sequencing and tick counter.
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           is_tick_i,
  input  wire logic [msp_pkg::HIGH_W-1:0]     high_ticks_i,
  input  wire logic [msp_pkg::GAP_W-1:0]      gap_ticks_i,
  input  wire logic                           all_done_i,
  output      logic [msp_pkg::TICK_W-1:0]     tick_q_o,
  output      logic [msp_pkg::PHASE_W-1:0]    phase_q_o,
  output      logic [msp_pkg::PHASE_W-1:0]    phase_d_o,
  output      msp_pkg::frame_ctl_t            ctl_o
);

  logic [msp_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [msp_pkg::TICK_W-1:0]  tick_q, tick_d, tick_inc;

  assign tick_inc = tick_q + msp_pkg::TICK_W'(1);

  always_comb begin
    phase_d           = phase_q;
    tick_d            = tick_q;
    ctl_o.fall_tick   = 1'b0;
    ctl_o.frame_start = 1'b0;
    if (step_i && is_tick_i) begin
      case (phase_q)
        msp_pkg::PH_LEAD: begin
          if (tick_inc >= msp_pkg::TICK_W'(high_ticks_i)) begin
            phase_d = msp_pkg::PH_FALL;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        msp_pkg::PH_FALL: begin
          ctl_o.fall_tick = 1'b1;
          if (all_done_i) begin
            phase_d = msp_pkg::PH_GAP;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        msp_pkg::PH_GAP: begin
          // counter wrap also ends the gap
          if (tick_inc >= gap_ticks_i || tick_inc == '0) begin
            ctl_o.frame_start = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: begin
          ctl_o.frame_start = 1'b1;
        end
      endcase
      if (ctl_o.frame_start) begin
        phase_d = msp_pkg::PH_LEAD;
        tick_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= msp_pkg::PH_LEAD;
      tick_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
    end
  end

  assign tick_q_o  = tick_q;
  assign phase_q_o = phase_q;
  assign phase_d_o = phase_d;

endmodule

`default_nettype wire

@@ design/msp_chan_bank.sv @@
// Per-channel shadow/active positions, compares and pin levels.
`timescale 1ns / 1ps
`default_nettype none

module msp_chan_bank #(
  parameter int unsigned NUM_CHANNELS = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire msp_pkg::in_item_t            item_i,
  input  wire logic [msp_pkg::POS_W-1:0]    min_value_i,
  input  wire logic [msp_pkg::POS_W-1:0]    max_value_i,
  input  wire msp_pkg::frame_ctl_t          ctl_i,
  input  wire logic [msp_pkg::TICK_W-1:0]   tick_q_i,
  output      logic                         all_done_o,
  output      logic [NUM_CHANNELS-1:0]      levels_q_o,
  output      logic                         pending_q_o,
  output      logic [msp_pkg::PIN_W-1:0]    pin_levels_o,
  output      logic                         accepted_o,
  output      logic [msp_pkg::POS_W-1:0]    read_value_o
);

  logic [msp_pkg::POS_W-1:0] shadow_q [NUM_CHANNELS];
  logic [msp_pkg::POS_W-1:0] shadow_d [NUM_CHANNELS];
  logic [msp_pkg::POS_W-1:0] active_q [NUM_CHANNELS];
  logic [msp_pkg::POS_W-1:0] active_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]   levels_q, levels_d, eq, le, hit;
  logic                      pending_q, pending_d;
  logic                      set_one, set_all;
  logic [msp_pkg::POS_W-1:0] clamped, rd;

  assign set_one = step_i && item_i.cmd == msp_pkg::CMD_SET_ONE && !pending_q;
  assign set_all = step_i && item_i.cmd == msp_pkg::CMD_SET_ALL && !pending_q;
  assign clamped = msp_pkg::clamp_pos(item_i.position, min_value_i, max_value_i);

  always_comb begin
    rd = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit[i] = item_i.channel == msp_pkg::CH_W'(i);
      eq[i]  = msp_pkg::TICK_W'(active_q[i]) == tick_q_i;
      le[i]  = msp_pkg::TICK_W'(active_q[i]) <= tick_q_i;
      shadow_d[i] = (set_all || (set_one && hit[i])) ? clamped : shadow_q[i];
      active_d[i] = (ctl_i.frame_start && pending_q) ? shadow_q[i] : active_q[i];
      if (hit[i]) begin
        rd = shadow_q[i];
      end
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (ctl_i.frame_start) begin
      pending_d = 1'b0;
    end else if (set_one || set_all) begin
      pending_d = 1'b1;
    end
    levels_d = levels_q;
    if (ctl_i.frame_start) begin
      levels_d = '1;
    end else if (ctl_i.fall_tick) begin
      levels_d = levels_q & ~eq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        shadow_q[i] <= msp_pkg::POS_RESET;
        active_q[i] <= msp_pkg::POS_RESET;
      end
      levels_q  <= '1;
      pending_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        shadow_q[i] <= shadow_d[i];
        active_q[i] <= active_d[i];
      end
      levels_q  <= levels_d;
      pending_q <= pending_d;
    end
  end

  for (genvar b = 0; b < msp_pkg::PIN_W; b++) begin : g_pin
    if (b < NUM_CHANNELS) begin : g_used
      assign pin_levels_o[b] = levels_d[b];
    end else begin : g_unused
      assign pin_levels_o[b] = 1'b0;
    end
  end

  assign all_done_o   = &le;
  assign levels_q_o   = levels_q;
  assign pending_q_o  = pending_q;
  assign accepted_o   = set_one || set_all;
  assign read_value_o = (item_i.cmd == msp_pkg::CMD_READ) ? rd : '0;

endmodule

`default_nettype wire

@@ design/multi_channel_servo_pulse_generator_unit.sv @@
// Top level of the multi-channel servo pulse generator.
`timescale 1ns / 1ps
`default_nettype none

// Servo pulse generator for NUM_CHANNELS pins. Each tick transaction (cmd 0)
// advances the frame: all pins high for high_ticks ticks, then a counter runs
// from 0 and each pin drops when the counter equals its active position; the
// phase ends once the counter reaches the largest position, and a low gap of
// gap_ticks ticks follows. Set commands (1 one channel, 2 all channels) clamp
// the position to [min_value, max_value] and write the shadow set; while an
// update is pending further sets are refused (accepted = 0). Shadow values
// become active at the next frame start. Read (cmd 3) returns the shadow
// value, or 0 for an out-of-range channel. Every input transaction yields
// exactly one result transaction. Throughput is one transaction per clock
// while the output is ready; each transaction passes the input register,
// then the result register; a waiting result holds the input register. All
// per-channel compares run in parallel in the single stage between the two
// registers. The user must write registers via cfg_we_i/cfg_idx_i/cfg_data_i
// only while no transaction is in flight; the block does not enforce this. A
// zero high_ticks or gap_ticks acts as one tick.

module multi_channel_servo_pulse_generator_unit #(
  parameter int unsigned NUM_CHANNELS = 18
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  msp_stream_if.sink                           in_i,
  msp_stream_if.source                         out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [msp_pkg::CFG_W-1:0]       cfg_data_i
);

  // Configuration registers
  logic [msp_pkg::POS_W-1:0]  min_q, max_q;
  logic [msp_pkg::HIGH_W-1:0] high_q;
  logic [msp_pkg::GAP_W-1:0]  gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= msp_pkg::MIN_RESET;
      max_q  <= msp_pkg::MAX_RESET;
      high_q <= msp_pkg::HIGH_RESET;
      gap_q  <= msp_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msp_pkg::REG_MIN:  min_q  <= cfg_data_i[msp_pkg::POS_W-1:0];
        msp_pkg::REG_MAX:  max_q  <= cfg_data_i[msp_pkg::POS_W-1:0];
        msp_pkg::REG_HIGH: high_q <= cfg_data_i[msp_pkg::HIGH_W-1:0];
        msp_pkg::REG_GAP:  gap_q  <= cfg_data_i[msp_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  msp_pkg::in_item_t  in_q;
  logic               in_vld_q;
  logic               advance;
  logic               in_take;

  // Result register
  msp_pkg::out_item_t out_q, res;
  logic               out_vld_q;

  // A transaction in the input register moves on when the result slot frees
  assign advance   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Frame timer and channel bank
  msp_pkg::frame_ctl_t          ctl;
  logic [msp_pkg::TICK_W-1:0]   tick_q;
  logic [msp_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic                         all_done;
  logic [NUM_CHANNELS-1:0]      levels_q;
  logic                         pending_q;

  msp_frame_ctrl u_frame_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .is_tick_i    (in_q.cmd == msp_pkg::CMD_TICK),
    .high_ticks_i (high_q),
    .gap_ticks_i  (gap_q),
    .all_done_i   (all_done),
    .tick_q_o     (tick_q),
    .phase_q_o    (phase_q),
    .phase_d_o    (phase_d),
    .ctl_o        (ctl)
  );

  msp_chan_bank #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_q),
    .min_value_i  (min_q),
    .max_value_i  (max_q),
    .ctl_i        (ctl),
    .tick_q_i     (tick_q),
    .all_done_o   (all_done),
    .levels_q_o   (levels_q),
    .pending_q_o  (pending_q),
    .pin_levels_o (res.pin_levels),
    .accepted_o   (res.accepted),
    .read_value_o (res.read_value)
  );

  assign res.phase_now = phase_d;

  // Assertions
  // Only tick transactions move the frame.
  a_phase_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.cmd != msp_pkg::CMD_TICK |=> $stable(phase_q))
    else $error("frame phase changed on a non-tick transaction");

  // Every pin is high throughout the lead phase.
  a_lead_all_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == msp_pkg::PH_LEAD |-> &levels_q)
    else $error("pin low during lead phase");

  // A frame start always consumes a pending update.
  a_start_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.frame_start |=> !pending_q)
    else $error("update still pending after frame start");

  // An accepted set comes only from a set command while no update is pending.
  a_accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.accepted |-> !pending_q &&
      (in_q.cmd == msp_pkg::CMD_SET_ONE || in_q.cmd == msp_pkg::CMD_SET_ALL))
    else $error("set accepted while update pending or for non-set command");

endmodule

`default_nettype wire
